// ===== hw/rtl/dftl_pkg.sv =====
// Shared constants, codes and types of the deadline FIFO timeout list.
package dftl_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int TIME_W    = 40;
  localparam int VAL_W     = 32;
  localparam int AGE_W     = 32;
  localparam int LIM_W     = 5;
  localparam int WAIT_W    = 42;
  localparam int MODE_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;
  localparam int MAX_RES   = 16;
  localparam int WCNT_W    = $clog2(MAX_RES + 1);
  localparam int ENT_W     = TIME_W + VAL_W;
  localparam int DATA_W    = 80;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [AGE_W-1:0] MAX_AGE_RST    = AGE_W'(1000);
  localparam logic [LIM_W-1:0] ITEM_LIMIT_RST = LIM_W'(16);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXPIRE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_LIMIT = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [AGE_W-1:0]  max_age;
    logic [TIME_W-1:0] head_deadline;
    logic              head_dead;
    logic              walk_all;
    logic              empty;
  } calc_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic              overdue;
    logic [WAIT_W-1:0] wait_ms;
  } calc_res_t;

endpackage

// ===== hw/rtl/dftl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dftl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/dftl_calc.sv =====
// Deadline arithmetic: saturated new deadline, overdue test and query wait.
module dftl_calc (
  input  dftl_pkg::calc_req_t req,
  output dftl_pkg::calc_res_t res
);

  logic [dftl_pkg::TIME_W:0]   sum;
  logic                        due;
  logic [dftl_pkg::TIME_W-1:0] diff;

  assign sum  = {1'b0, req.now_ms}
              + {{(dftl_pkg::TIME_W - dftl_pkg::AGE_W + 1){1'b0}}, req.max_age};
  assign due  = req.head_deadline <= req.now_ms;
  assign diff = req.head_deadline - req.now_ms;

  always_comb begin
    res.deadline = sum[dftl_pkg::TIME_W] ? dftl_pkg::TIME_MAX
                                         : sum[dftl_pkg::TIME_W-1:0];
    res.overdue  = !req.head_dead && (req.walk_all || due);
    if (req.empty) begin
      res.wait_ms = {dftl_pkg::WAIT_W{1'b1}};
    end else if (req.head_dead || due) begin
      res.wait_ms = dftl_pkg::WAIT_W'(1);
    end else begin
      res.wait_ms = dftl_pkg::WAIT_W'(diff) + dftl_pkg::WAIT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/deadline_fifo_timeout_list_top.sv =====
// Deadline FIFO timeout list: ring of timed entries with lazy deletion.
//
// One input word carries an operation (in_tuser) and its operands; every
// accepted word of a defined mode gives one or more result words, the final
// one marked by out_tlast. Add, remove, clear and query give one result;
// expire and cancel walk the head of the ring and give one result per
// emitted entry (at most 16), or a single "nothing to emit" result.
// Timing: a single-result word is registered into the output register once
// that register is free; a walk holds each emitted entry back until the next
// head entry has been seen, so that its last flag is known.
// Throughput: one word at a time. Expire and cancel retire one head entry a
// cycle through the single read port of the entry RAM, unless a held output
// word blocks the next emission. The next input word is taken once the walk
// has finished, while the last result may still sit in the output register.
// A stalled receiver holds the output register; the walk then holds too.
// Reset (synchronous, rst_n low) empties the ring and restores max_age to
// 1000 and item_limit to 16. The user must write configuration only while
// idle; the block itself does not enforce it.
module deadline_fifo_timeout_list_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // now_ms [39:0], item_value [71:40], slot_handle [75:72], zero [79:76]
  input  logic [dftl_pkg::DATA_W-1:0]       in_tdata,
  // mode [2:0]
  input  logic [dftl_pkg::MODE_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // handle_out [3:0], value_out [35:4], wait_ms [77:36], zero [79:78]
  output logic [dftl_pkg::DATA_W-1:0]       out_tdata,
  // status [1:0]
  output logic [dftl_pkg::STAT_W-1:0]       out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [dftl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dftl_pkg::CFG_W-1:0]        cfg_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  logic [dftl_pkg::MODE_W-1:0] mode_r;
  logic [dftl_pkg::TIME_W-1:0] now_r;
  logic [dftl_pkg::VAL_W-1:0]  val_r;
  logic [dftl_pkg::IDX_W-1:0]  handle_r;

  logic [dftl_pkg::AGE_W-1:0]  max_age_r;
  logic [dftl_pkg::LIM_W-1:0]  item_limit_r;

  logic [dftl_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [dftl_pkg::IDX_W-1:0]  tail_r, tail_nxt;
  logic [dftl_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [dftl_pkg::DEPTH-1:0]  dead_r, dead_nxt;
  logic [dftl_pkg::DEPTH-1:0]  used_r, used_nxt;

  logic [dftl_pkg::WCNT_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic                        pend_vld_r, pend_vld_nxt;
  logic [dftl_pkg::IDX_W-1:0]  pend_handle_r, pend_handle_nxt;
  logic [dftl_pkg::VAL_W-1:0]  pend_value_r, pend_value_nxt;

  logic                        out_vld_r, out_vld_nxt;
  logic [dftl_pkg::STAT_W-1:0] out_status_r;
  logic [dftl_pkg::IDX_W-1:0]  out_handle_r;
  logic [dftl_pkg::VAL_W-1:0]  out_value_r;
  logic [dftl_pkg::WAIT_W-1:0] out_wait_r;
  logic                        out_last_r;

  logic                        push;
  logic [dftl_pkg::STAT_W-1:0] push_status;
  logic [dftl_pkg::IDX_W-1:0]  push_handle;
  logic [dftl_pkg::VAL_W-1:0]  push_value;
  logic [dftl_pkg::WAIT_W-1:0] push_wait;
  logic                        push_last;

  logic                        ram_we;
  logic [dftl_pkg::ENT_W-1:0]  ram_rdata;
  logic [dftl_pkg::TIME_W-1:0] head_deadline;
  logic [dftl_pkg::VAL_W-1:0]  head_value;

  dftl_pkg::calc_req_t calc_req;
  dftl_pkg::calc_res_t calc_res;

  logic                        in_acc;
  logic                        out_free;
  logic                        full;
  logic [dftl_pkg::CNT_W-1:0]  limit;
  logic                        walk_stop;

  assign in_tready = state_r == S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  assign head_deadline = ram_rdata[dftl_pkg::ENT_W-1:dftl_pkg::VAL_W];
  assign head_value    = ram_rdata[dftl_pkg::VAL_W-1:0];

  assign limit = (item_limit_r > dftl_pkg::LIM_W'(dftl_pkg::DEPTH))
               ? dftl_pkg::CNT_W'(dftl_pkg::DEPTH) : dftl_pkg::CNT_W'(item_limit_r);
  assign full  = count_r >= limit;

  always_comb begin
    calc_req.now_ms        = now_r;
    calc_req.max_age       = max_age_r;
    calc_req.head_deadline = head_deadline;
    calc_req.head_dead     = dead_r[head_r];
    calc_req.walk_all      = mode_r == dftl_pkg::MODE_CANCEL;
    calc_req.empty         = count_r == '0;
  end

  dftl_calc u_calc (
    .req (calc_req),
    .res (calc_res)
  );

  // Entry store: deadline above value, read at the head every cycle
  dftl_ram #(
    .WIDTH (dftl_pkg::ENT_W),
    .DEPTH (dftl_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata ({calc_res.deadline, val_r}),
    .re    (1'b1),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  assign walk_stop = (count_r == '0)
                  || (walk_cnt_r == dftl_pkg::WCNT_W'(dftl_pkg::MAX_RES))
                  || (!dead_r[head_r] && !calc_res.overdue);

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    dead_nxt        = dead_r;
    used_nxt        = used_r;
    walk_cnt_nxt    = walk_cnt_r;
    pend_vld_nxt    = pend_vld_r;
    pend_handle_nxt = pend_handle_r;
    pend_value_nxt  = pend_value_r;
    ram_we          = 1'b0;
    push            = 1'b0;
    push_status     = dftl_pkg::ST_OK;
    push_handle     = '0;
    push_value      = '0;
    push_wait       = '0;
    push_last       = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_EXEC;
          walk_cnt_nxt = '0;
          pend_vld_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        unique case (mode_r) inside
          dftl_pkg::MODE_ADD: begin
            if (out_free) begin
              push      = 1'b1;
              state_nxt = S_IDLE;
              if (full) begin
                push_status = dftl_pkg::ST_FULL;
              end else begin
                ram_we           = 1'b1;
                push_handle      = tail_r;
                used_nxt[tail_r] = 1'b1;
                dead_nxt[tail_r] = 1'b0;
                tail_nxt         = tail_r + 1'b1;
                count_nxt        = count_r + 1'b1;
              end
            end
          end
          dftl_pkg::MODE_REMOVE: begin
            if (out_free) begin
              push        = 1'b1;
              push_handle = handle_r;
              state_nxt   = S_IDLE;
              if (used_r[handle_r]) begin
                dead_nxt[handle_r] = 1'b1;
              end
            end
          end
          dftl_pkg::MODE_CLEAR: begin
            if (out_free) begin
              push      = 1'b1;
              state_nxt = S_IDLE;
              dead_nxt  = '0;
              used_nxt  = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
          end
          dftl_pkg::MODE_QUERY: begin
            if (out_free) begin
              push      = 1'b1;
              push_wait = calc_res.wait_ms;
              state_nxt = S_IDLE;
            end
          end
          dftl_pkg::MODE_EXPIRE, dftl_pkg::MODE_CANCEL: begin
            if (walk_stop) begin
              // flush the held entry as the final word, or report none
              if (out_free) begin
                push      = 1'b1;
                state_nxt = S_IDLE;
                if (pend_vld_r) begin
                  push_handle = pend_handle_r;
                  push_value  = pend_value_r;
                end else begin
                  push_status = dftl_pkg::ST_NONE;
                end
              end
            end else if (!(calc_res.overdue && pend_vld_r) || out_free) begin
              // hold each emitted entry back in the pending register until its last flag is known
              if (calc_res.overdue) begin
                if (pend_vld_r) begin
                  push        = 1'b1;
                  push_handle = pend_handle_r;
                  push_value  = pend_value_r;
                  push_last   = 1'b0;
                end
                pend_vld_nxt    = 1'b1;
                pend_handle_nxt = head_r;
                pend_value_nxt  = head_value;
                walk_cnt_nxt    = walk_cnt_r + 1'b1;
              end
              used_nxt[head_r] = 1'b0;
              dead_nxt[head_r] = 1'b0;
              head_nxt         = head_r + 1'b1;
              count_nxt        = count_r - 1'b1;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (push) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      dead_r     <= '0;
      used_r     <= '0;
      walk_cnt_r <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      dead_r     <= dead_nxt;
      used_r     <= used_nxt;
      walk_cnt_r <= walk_cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r    <= dftl_pkg::MAX_AGE_RST;
      item_limit_r <= dftl_pkg::ITEM_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dftl_pkg::REG_MAX_AGE:    max_age_r    <= cfg_data[dftl_pkg::AGE_W-1:0];
        dftl_pkg::REG_ITEM_LIMIT: item_limit_r <= cfg_data[dftl_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r   <= in_tuser;
      now_r    <= in_tdata[39:0];
      val_r    <= in_tdata[71:40];
      handle_r <= in_tdata[75:72];
    end
    pend_handle_r <= pend_handle_nxt;
    pend_value_r  <= pend_value_nxt;
    if (push) begin
      out_status_r <= push_status;
      out_handle_r <= push_handle;
      out_value_r  <= push_value;
      out_wait_r   <= push_wait;
      out_last_r   <= push_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_wait_r, out_value_r, out_handle_r};

  a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(count_r))
    else $error("entry count does not match occupied slots");

  a_dead_only_used: assert property (@(posedge clk) disable iff (!rst_n)
    (dead_r & ~used_r) == '0)
    else $error("dead mark on an empty slot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dftl_pkg::CNT_W'(dftl_pkg::DEPTH))
    else $error("entry count beyond ring depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    walk_cnt_r <= dftl_pkg::WCNT_W'(dftl_pkg::MAX_RES))
    else $error("walk emitted more than the result limit");

  a_push_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (state_r == S_EXEC) && out_free)
    else $error("result word pushed outside execution or over a held word");

  a_ring_span: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != dftl_pkg::CNT_W'(dftl_pkg::DEPTH)) && (count_r != '0)
      |-> (dftl_pkg::IDX_W'(head_r + dftl_pkg::IDX_W'(count_r)) == tail_r))
    else $error("head, tail and entry count disagree");

endmodule

// ===== dv/deadline_fifo_timeout_list_checker.sv =====
// Channel monitor, ring predictor and result scoreboard for the deadline FIFO timeout list.
module deadline_fifo_timeout_list_checker
  import dftl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,
  input  logic [MODE_W-1:0]    in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [DATA_W-1:0]    out_tdata,
  input  logic [STAT_W-1:0]    out_tuser,
  input  logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   results_pending
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  handle;
    logic [VAL_W-1:0]  value;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } timer_res_t;

  logic [TIME_W-1:0] ring_deadline [DEPTH];
  logic [VAL_W-1:0]  ring_value    [DEPTH];
  logic              ring_dead     [DEPTH];
  logic              ring_used     [DEPTH];
  logic [IDX_W-1:0]  ring_head;
  logic [IDX_W-1:0]  ring_tail;
  logic [CNT_W-1:0]  ring_count;
  logic [AGE_W-1:0]  age_setting;
  logic [LIM_W-1:0]  limit_setting;

  timer_res_t timer_results_q [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  task automatic push_result(logic [STAT_W-1:0] st, logic [IDX_W-1:0] h,
                             logic [VAL_W-1:0] v, logic [WAIT_W-1:0] w, logic l);
    timer_res_t r;
    r.status  = st;
    r.handle  = h;
    r.value   = v;
    r.wait_ms = w;
    r.last    = l;
    timer_results_q.push_back(r);
  endtask

  task automatic empty_ring();
    for (int i = 0; i < DEPTH; i++) begin
      ring_dead[i] = 1'b0;
      ring_used[i] = 1'b0;
    end
    ring_head  = '0;
    ring_tail  = '0;
    ring_count = '0;
  endtask

  // Pop dead or overdue head entries, at most MAX_RES emitted per word.
  task automatic walk_head(logic [TIME_W-1:0] now, logic take_all);
    int               emitted;
    logic [IDX_W-1:0] h;
    logic             dead;
    logic             overdue;
    emitted = 0;
    while (ring_count > 0 && emitted < MAX_RES) begin
      h       = ring_head;
      dead    = ring_dead[h];
      overdue = !dead && (take_all || ring_deadline[h] <= now);
      if (!dead && !overdue) break;
      if (overdue) begin
        push_result(ST_OK, h, ring_value[h], '0, 1'b0);
        emitted++;
      end
      ring_used[h] = 1'b0;
      ring_dead[h] = 1'b0;
      ring_head    = h + 1'b1;
      ring_count   = ring_count - 1'b1;
    end
    if (emitted == 0)
      push_result(ST_NONE, '0, '0, '0, 1'b1);
    else
      timer_results_q[timer_results_q.size()-1].last = 1'b1;
  endtask

  task automatic run_timer_op(logic [MODE_W-1:0] op, logic [TIME_W-1:0] now,
                              logic [VAL_W-1:0] val, logic [IDX_W-1:0] hnd);
    logic [CNT_W-1:0]  lim;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] d;
    logic [WAIT_W-1:0] w;
    case (op)
      MODE_ADD: begin
        lim = (limit_setting > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(limit_setting);
        if (ring_count >= lim) begin
          push_result(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          sum = {1'b0, now} + (TIME_W+1)'(age_setting);
          ring_deadline[ring_tail] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          ring_value[ring_tail]    = val;
          ring_dead[ring_tail]     = 1'b0;
          ring_used[ring_tail]     = 1'b1;
          push_result(ST_OK, ring_tail, '0, '0, 1'b1);
          ring_tail  = ring_tail + 1'b1;
          ring_count = ring_count + 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (ring_used[hnd]) ring_dead[hnd] = 1'b1;
        push_result(ST_OK, hnd, '0, '0, 1'b1);
      end
      MODE_EXPIRE: walk_head(now, 1'b0);
      MODE_CANCEL: walk_head(now, 1'b1);
      MODE_CLEAR: begin
        empty_ring();
        push_result(ST_OK, '0, '0, '0, 1'b1);
      end
      MODE_QUERY: begin
        if (ring_count == 0) begin
          w = '1;
        end else if (ring_dead[ring_head]) begin
          w = WAIT_W'(1);
        end else begin
          d = ring_deadline[ring_head];
          w = (d <= now) ? WAIT_W'(1) : WAIT_W'(d - now) + WAIT_W'(1);
        end
        push_result(ST_OK, '0, '0, w, 1'b1);
      end
      default: ; // undefined modes leave the ring alone and answer nothing
    endcase
  endtask

  task automatic check_result(timer_res_t got);
    timer_res_t exp;
    if (timer_results_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result word: st=%0d h=%0d v=%h w=%h last=%0b",
                 got.status, got.handle, got.value, got.wait_ms, got.last);
    end else begin
      exp = timer_results_q.pop_front();
      if (got.status !== exp.status || got.handle !== exp.handle ||
          got.value !== exp.value || got.wait_ms !== exp.wait_ms ||
          got.last !== exp.last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"mismatch: expected st=%0d h=%0d v=%h w=%h last=%0b, ",
                    "got st=%0d h=%0d v=%h w=%h last=%0b"},
                   exp.status, exp.handle, exp.value, exp.wait_ms, exp.last,
                   got.status, got.handle, got.value, got.wait_ms, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_ring();
      age_setting   = MAX_AGE_RST;
      limit_setting = ITEM_LIMIT_RST;
      timer_results_q.delete();
    end else begin
      if (out_tvalid && out_tready)
        check_result({out_tuser, out_tdata[IDX_W-1:0], out_tdata[IDX_W +: VAL_W],
                      out_tdata[IDX_W+VAL_W +: WAIT_W], out_tlast});
      if (cfg_we) begin
        if (cfg_index == REG_MAX_AGE)
          age_setting = cfg_data[AGE_W-1:0];
        else if (cfg_index == REG_ITEM_LIMIT)
          limit_setting = cfg_data[LIM_W-1:0];
      end
      if (in_tvalid && in_tready)
        run_timer_op(in_tuser, in_tdata[TIME_W-1:0], in_tdata[TIME_W +: VAL_W],
                     in_tdata[TIME_W+VAL_W +: IDX_W]);
    end
    results_pending = timer_results_q.size();
  end

endmodule

// ===== dv/deadline_fifo_timeout_list_top_tb.sv =====
// Stimulus, clocking and verdict for the deadline FIFO timeout list block.
module deadline_fifo_timeout_list_top_tb;
  import dftl_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 8;
  localparam int WORDS_PER_PHASE = 42;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // now_ms [39:0], item_value [71:40], slot_handle [75:72], zero [79:76]
  logic [DATA_W-1:0]    in_tdata;
  // mode [2:0]
  logic [MODE_W-1:0]    in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  // handle_out [3:0], value_out [35:4], wait_ms [77:36], zero [79:78]
  logic [DATA_W-1:0]    out_tdata;
  // status [1:0]
  logic [STAT_W-1:0]    out_tuser;
  logic                 out_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int                   mismatch_count;
  int                   results_pending;
  int                   quiet_cycles = 0;
  logic                 gaps_on;
  logic [TIME_W-1:0]    sim_ms;

  deadline_fifo_timeout_list_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  deadline_fifo_timeout_list_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic [MODE_W-1:0] op, logic [TIME_W-1:0] now,
                           logic [VAL_W-1:0] val, logic [IDX_W-1:0] hnd);
    int gap;
    gap = gaps_on ? pause_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(DATA_W-TIME_W-VAL_W-IDX_W){1'b0}}, hnd, val, now};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid, let every result arrive, then allow the pipeline to settle.
  task automatic drain_and_hold();
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_regs(logic [AGE_W-1:0] age, logic [LIM_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_AGE;
    cfg_data  <= CFG_W'(age);
    @(negedge clk);
    cfg_index <= REG_ITEM_LIMIT;
    cfg_data  <= CFG_W'(lim);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_word(int step_max);
    logic [MODE_W-1:0] op;
    logic [TIME_W-1:0] now;
    int                p;
    p = $urandom_range(0, 99);
    if (p < 36)      op = MODE_ADD;
    else if (p < 50) op = MODE_REMOVE;
    else if (p < 68) op = MODE_EXPIRE;
    else if (p < 73) op = MODE_CANCEL;
    else if (p < 77) op = MODE_CLEAR;
    else if (p < 96) op = MODE_QUERY;
    else             op = ($urandom_range(0, 1) == 0) ? MODE_UNDEF_LO : MODE_UNDEF_HI;
    if ($urandom_range(0, 9) == 0) begin
      now = rand_time();
    end else begin
      sim_ms = sim_ms + TIME_W'($urandom_range(0, step_max));
      now    = sim_ms;
    end
    send_word(op, now, $urandom(), IDX_W'($urandom_range(0, 15)));
  endtask

  // Receiver: bursts of ready broken by stalls, with occasional long clean stretches.
  initial begin
    int on;
    int off;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      on = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (on) @(negedge clk);
      off = pause_len();
      if (off > 0) begin
        out_tready <= 1'b0;
        repeat (off) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [AGE_W-1:0] age;
    logic [LIM_W-1:0] lim;
    int               step;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_ADD;
    cfg_we    = 1'b0;
    cfg_index = REG_MAX_AGE;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    sim_ms    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: max_age 1000, item_limit 16
    send_word(MODE_QUERY, '0, '0, '0);              // empty ring
    send_word(MODE_EXPIRE, TIME_MAX, '0, '0);       // nothing to emit
    send_word(MODE_CANCEL, '0, '0, '0);
    send_word(MODE_ADD, '0, '0, '0);
    send_word(MODE_ADD, TIME_MAX, '1, '1);          // deadline saturates
    send_word(MODE_QUERY, '0, '0, '0);
    send_word(MODE_REMOVE, '0, '0, '0);
    send_word(MODE_QUERY, TIME_W'(5), '0, '0);      // dead head
    send_word(MODE_REMOVE, '0, '0, '1);             // slot never filled
    send_word(MODE_EXPIRE, TIME_W'(1000), '0, '0);  // pops only the dead head
    send_word(MODE_QUERY, TIME_MAX, '0, '0);        // overdue head
    send_word(MODE_EXPIRE, TIME_MAX, '0, '0);
    send_word(MODE_ADD, TIME_W'(7), 32'h5a5a_5a5a, IDX_W'(3));
    send_word(MODE_CLEAR, '0, '0, '0);
    send_word(MODE_UNDEF_LO, rand_time(), $urandom(), '0);
    send_word(MODE_UNDEF_HI, rand_time(), $urandom(), '1);
    drain_and_hold();

    // Full ring, then a cancel that hits the emission cap
    set_regs('0, LIM_W'(DEPTH));
    for (int i = 0; i < DEPTH; i++)
      send_word(MODE_ADD, TIME_W'(100), $urandom(), '0);
    send_word(MODE_ADD, TIME_W'(100), $urandom(), '0);
    send_word(MODE_EXPIRE, TIME_W'(50), '0, '0);
    send_word(MODE_CANCEL, '0, '0, '0);
    send_word(MODE_CANCEL, '0, '0, '0);
    drain_and_hold();
    set_regs(AGE_W'(1000), '0);
    send_word(MODE_ADD, TIME_W'(1), $urandom(), '0);
    send_word(MODE_QUERY, TIME_W'(1), '0, '0);
    drain_and_hold();

    for (int ph = 0; ph < PHASES; ph++) begin
      sim_ms  = rand_time();
      gaps_on = 1'b1;
      case (ph)
        0: begin age = '0;  lim = LIM_W'(DEPTH); step = 4; end
        1: begin age = '1;  lim = LIM_W'(DEPTH); step = 1000; gaps_on = 1'b0; end
        2: begin age = AGE_W'($urandom_range(1, 100)); lim = LIM_W'(1); step = 40; end
        3: begin age = AGE_W'($urandom_range(1, 100)); lim = '0; step = 40; end
        4: begin
          age = AGE_W'($urandom_range(1, 300)); lim = LIM_W'($urandom_range(2, 15)); step = 50;
        end
        5: begin age = $urandom(); lim = LIM_W'(DEPTH); step = 100000; end
        6: begin
          // close to the top of the time range, so deadlines saturate
          age = AGE_W'(50); lim = LIM_W'(DEPTH); step = 10; gaps_on = 1'b0;
          sim_ms = TIME_MAX - TIME_W'($urandom_range(0, 500));
        end
        default: begin
          age = AGE_W'($urandom_range(1, 500)); lim = LIM_W'($urandom_range(8, 16)); step = 100;
        end
      endcase
      set_regs(age, lim);
      for (int k = 0; k < WORDS_PER_PHASE; k++)
        random_word(step);
      drain_and_hold();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dftl_pkg.sv
hw/rtl/dftl_ram.sv
hw/rtl/dftl_calc.sv
hw/rtl/deadline_fifo_timeout_list_top.sv
dv/deadline_fifo_timeout_list_checker.sv
dv/deadline_fifo_timeout_list_top_tb.sv
